// File: hw/rtl/sst_pkg.sv
// Package for the sorted set toggle block: sizes, sequencer states, compare result type.
// Used by the top, the compare unit and the checker. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package sst_pkg;

   localparam int DEPTH = 16;
   localparam int KEY_W = 32;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = 4;
   localparam int OCC_W = 5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH,
      ST_CMP,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_INS_RD,
      ST_INS_WR,
      ST_INS_KEY,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic less;
      logic equal;
   } cmp_res_type;

endpackage
`default_nettype wire

// File: hw/rtl/sorted_set_toggle_top.sv
// Sorted set toggle: ascending table of signed keys; each item removes or inserts its key.
// Depends on sst_pkg, sst_ram and sst_cmp.
//
// Each key is looked up by binary search in a single table RAM (one write port, one
// registered read port) through one shared compare unit, then the entries above the
// affected position are moved one place at a time, each read then written over the same
// RAM ports. An insert writes its key after the moves. The number of probes is at most
// log2(count)+1, and a miss on a full table moves nothing. The table starts empty at
// reset without any clearing pass. A result waits in an output register; the next item
// is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none
module sorted_set_toggle_top
   import sst_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic signed [KEY_W-1:0] req_key,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_hit,
   output logic             [POS_W-1:0] rsp_position,
   output logic                         rsp_full_res,
   output logic             [OCC_W-1:0] rsp_count_after
);

   state_type state_ff, state_in;

   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             hit_ff, hit_in;
   logic             full_ff, full_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff, rsp_hit_in;
   logic             rsp_full_ff, rsp_full_in;
   logic [CNT_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [CNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [KEY_W-1:0] ram_wdata;
   logic [IDX_W-1:0] ram_raddr;
   logic [KEY_W-1:0] ram_rdata;
   cmp_res_type      cmp_res;

   logic [CNT_W-1:0] mid;
   logic [CNT_W-1:0] idx_ext;
   logic             srch_done;
   logic             del_first;
   logic             del_more;
   logic             ins_first;
   logic             ins_more;
   logic             is_full;
   logic             can_load;
   logic [31:0]      pos_wide;
   logic [31:0]      cnt_wide;

   sst_ram #(
      .WIDTH(KEY_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   sst_cmp u_cmp (
      .entry (signed'(ram_rdata)),
      .key   (key_ff),
      .res   (cmp_res)
   );

   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_ext   = CNT_W'(idx_ff);
   assign srch_done = !(lo_ff < hi_ff);
   assign del_first = (lo_ff + CNT_W'(1)) < occ_ff;
   assign del_more  = (idx_ext + CNT_W'(2)) < occ_ff;
   assign ins_first = occ_ff > lo_ff;
   assign ins_more  = (idx_ext - CNT_W'(1)) > lo_ff;
   assign is_full   = occ_ff >= CNT_W'(DEPTH);
   assign can_load  = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            if (!srch_done) begin
               state_in = ST_CMP;
            end else if (hit_ff) begin
               state_in = del_first ? ST_DEL_RD : ST_FIN;
            end else if (is_full) begin
               state_in = ST_FIN;
            end else begin
               state_in = ins_first ? ST_INS_RD : ST_INS_KEY;
            end
         end
         ST_CMP:     state_in = ST_SRCH;
         ST_DEL_RD:  state_in = ST_DEL_WR;
         ST_DEL_WR:  state_in = del_more ? ST_DEL_RD : ST_FIN;
         ST_INS_RD:  state_in = ST_INS_WR;
         ST_INS_WR:  state_in = ins_more ? ST_INS_RD : ST_INS_KEY;
         ST_INS_KEY: state_in = ST_FIN;
         ST_FIN: begin
            if (can_load) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff;
      ram_wdata    = ram_rdata;
      ram_raddr    = mid[IDX_W-1:0];
      key_in       = key_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      occ_in       = occ_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            key_in    = req_key;
            lo_in     = '0;
            hi_in     = occ_ff;
            hit_in    = 1'b0;
            full_in   = 1'b0;
         end
         ST_SRCH: begin
            if (srch_done) begin
               if (hit_ff) begin
                  idx_in = lo_ff[IDX_W-1:0];
               end else if (is_full) begin
                  full_in = 1'b1;
               end else begin
                  idx_in = occ_ff[IDX_W-1:0];
               end
            end
         end
         ST_CMP: begin
            if (cmp_res.less) begin
               lo_in = mid + CNT_W'(1);
            end else begin
               hi_in = mid;
            end
            if (cmp_res.equal) begin
               hit_in = 1'b1;
            end
         end
         ST_DEL_RD: begin
            ram_raddr = idx_ff + IDX_W'(1);
         end
         ST_DEL_WR: begin
            ram_we = 1'b1;
            idx_in = idx_ff + IDX_W'(1);
         end
         ST_INS_RD: begin
            ram_raddr = idx_ff - IDX_W'(1);
         end
         ST_INS_WR: begin
            ram_we = 1'b1;
            idx_in = idx_ff - IDX_W'(1);
         end
         ST_INS_KEY: begin
            ram_we    = 1'b1;
            ram_waddr = lo_ff[IDX_W-1:0];
            ram_wdata = key_ff;
         end
         ST_FIN: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_full_in  = full_ff;
               rsp_pos_in   = full_ff ? '0 : lo_ff;
               if (hit_ff) begin
                  occ_in = occ_ff - CNT_W'(1);
               end else if (!full_ff) begin
                  occ_in = occ_ff + CNT_W'(1);
               end
               rsp_cnt_in = occ_in;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      idx_ff      <= idx_in;
      hit_ff      <= hit_in;
      full_ff     <= full_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_full_ff <= rsp_full_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   assign pos_wide = 32'(rsp_pos_ff);
   assign cnt_wide = 32'(rsp_cnt_ff);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_full_res    = rsp_full_ff;
   assign rsp_position    = pos_wide[POS_W-1:0];
   assign rsp_count_after = cnt_wide[OCC_W-1:0];

endmodule
`default_nettype wire

// File: hw/rtl/sst_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: hw/rtl/sst_cmp.sv
// Shared signed key compare unit: table entry against the looked-up key.
// Depends on sst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sst_cmp
   import sst_pkg::*;
(
   input  wire logic signed [KEY_W-1:0] entry,
   input  wire logic signed [KEY_W-1:0] key,
   output cmp_res_type                  res
);

   always_comb begin
      res.less  = entry < key;
      res.equal = entry == key;
   end

endmodule
`default_nettype wire

// File: hw/rtl/sst_checker.sv
// Port-level checker for sorted_set_toggle_top, attached by bind.
// Depends on sst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sst_checker
   import sst_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic signed [KEY_W-1:0] req_key,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic                    rsp_hit,
   input wire logic        [POS_W-1:0] rsp_position,
   input wire logic                    rsp_full_res,
   input wire logic        [OCC_W-1:0] rsp_count_after
);

   localparam logic [OCC_W-1:0] FULL_CNT = OCC_W'(DEPTH);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_position)
         && $stable(rsp_full_res) && $stable(rsp_count_after))
      else $error("result item changed while stalled");

   a_hit_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_full_res))
      else $error("hit and full flagged together");

   a_full_res: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_full_res |-> rsp_position == '0 && rsp_count_after == FULL_CNT)
      else $error("full result with bad position or count");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after an item was taken");

endmodule

bind sorted_set_toggle_top sst_checker u_sst_checker (.*);
`default_nettype wire

// File: verif/testbench.sv
// Testbench for sorted_set_toggle_top: toggles signed keys in and out of the sorted table.
// Each result is checked against a local model of the table. Depends on sst_pkg and the RTL.
`timescale 1ns / 1ps
module testbench;
   import sst_pkg::*;

   localparam int GAP_MAX       = 6;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 64;
   localparam int RANDOM_ITEMS  = 1000;
   localparam int POOL_MAX      = 48;
   localparam int REPORT_MAX    = 40;

   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

   typedef struct packed {
      logic             hit;
      logic [POS_W-1:0] position;
      logic             full_res;
      logic [OCC_W-1:0] count_after;
   } toggle_result_t;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic signed [KEY_W-1:0] req_key;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic                    rsp_hit;
   logic        [POS_W-1:0] rsp_position;
   logic                    rsp_full_res;
   logic        [OCC_W-1:0] rsp_count_after;

   logic signed [KEY_W-1:0] table_keys [DEPTH];
   int                      table_count = 0;
   toggle_result_t          pending_results [$];
   int                      mismatch_count = 0;
   int                      idle_cycles = 0;
   bit                      calm = 1'b0;

   always #4 clock = ~clock;

   sorted_set_toggle_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hit        (rsp_hit),
      .rsp_position   (rsp_position),
      .rsp_full_res   (rsp_full_res),
      .rsp_count_after(rsp_count_after)
   );

   // Applies one toggle to the local table and returns the result it must produce.
   function automatic toggle_result_t toggle_predict(input logic signed [KEY_W-1:0] key);
      toggle_result_t res;
      int             slot;
      res  = '0;
      slot = 0;
      while (slot < table_count && table_keys[slot] < key) slot++;
      if (slot < table_count && table_keys[slot] == key) begin
         res.hit      = 1'b1;
         res.position = POS_W'(slot);
         for (int i = slot; i < table_count - 1; i++) table_keys[i] = table_keys[i + 1];
         table_count--;
      end else if (table_count >= DEPTH) begin
         res.full_res = 1'b1;
      end else begin
         for (int i = table_count; i > slot; i--) table_keys[i] = table_keys[i - 1];
         table_keys[slot] = key;
         res.position     = POS_W'(slot);
         table_count++;
      end
      res.count_after = OCC_W'(table_count);
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   // Leaves valid high so back-to-back items follow without dropping valid.
   task automatic send_key(input logic signed [KEY_W-1:0] key);
      int gap;
      gap = calm ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_key   <= key;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(toggle_predict(key));
   endtask

   task automatic finish_phase();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic test_extremes();
      send_key(KEY_MIN);
      send_key(KEY_MAX);
      send_key('0);
      send_key('1);
      send_key(KEY_MIN);
      send_key(KEY_MAX);
      send_key('0);
      send_key('1);
      finish_phase();
   endtask

   // Fill from the top down, then miss on full, then remove the last and first entries.
   task automatic test_full_table();
      for (int i = DEPTH - 1; i >= 0; i--) send_key(KEY_W'(i * 1000 - 8000));
      send_key(KEY_W'(5));
      send_key(KEY_W'((DEPTH - 1) * 1000 - 8000));
      send_key(KEY_W'(-8000));
      finish_phase();
   endtask

   task automatic test_random_mix();
      logic signed [KEY_W-1:0] pool_keys [POOL_MAX];
      logic signed [KEY_W-1:0] key;
      int issued;
      int round_len;
      int hit_pct;
      int pool_size;
      int pick;
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         round_len = $urandom_range(40, 120);
         case ($urandom_range(0, 2))
            0: hit_pct = 20;
            1: hit_pct = 50;
            default: hit_pct = 80;
         endcase
         case ($urandom_range(0, 3))
            0: pool_size = 4;
            1: pool_size = 12;
            2: pool_size = 24;
            default: pool_size = POOL_MAX;
         endcase
         for (int i = 0; i < POOL_MAX; i++) begin
            case ($urandom_range(0, 3))
               0: pool_keys[i] = KEY_W'(int'($urandom_range(0, 31)) - 16);
               1: pool_keys[i] = $urandom_range(0, 1) ? KEY_MIN + i : KEY_MAX - i;
               default: pool_keys[i] = $urandom;
            endcase
         end
         calm = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < round_len; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < hit_pct && table_count > 0)
               key = table_keys[$urandom_range(0, table_count - 1)];
            else if (pick < 90)
               key = pool_keys[$urandom_range(0, pool_size - 1)];
            else
               key = $urandom;
            send_key(key);
         end
         issued += round_len;
      end
      calm = 1'b0;
      finish_phase();
   endtask

   initial begin
      toggle_result_t want;
      int stall;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = calm ? 0 : $urandom_range(0, GAP_MAX);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("%0t: result with none expected, expected none, got hit=%0d pos=%0d",
                        $time, rsp_hit, rsp_position);
         end else begin
            want = pending_results.pop_front();
            check_field("hit", want.hit, rsp_hit);
            check_field("position", want.position, rsp_position);
            check_field("full_res", want.full_res, rsp_full_res);
            check_field("count_after", want.count_after, rsp_count_after);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_key   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_full_table();
      test_random_mix();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/sst_pkg.sv
hw/rtl/sst_ram.sv
hw/rtl/sst_cmp.sv
hw/rtl/sorted_set_toggle_top.sv
hw/rtl/sst_checker.sv
verif/testbench.sv
